/* rtl/core/wbis_pkg.sv */
// ----------------------------------------------------------------------------
// wbis_pkg
// Types, constants and codes shared by the wheel and button sampler modules.
// ----------------------------------------------------------------------------
package wbis_pkg;

    // Fixed sizes of the block
    localparam int WHEEL_RANGE  = 255;
    localparam int BUTTONS      = 3;
    localparam int CALIB_W      = 10;
    localparam int INTERVAL_W   = 8;
    localparam int POS_W        = 8;
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 8;
    localparam int EVENT_W      = 2 * BUTTONS;

    // Configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = CALIB_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CALIB_W-1:0]    CALIB_LOW_RST  = 10'd100;
    localparam logic [CALIB_W-1:0]    CALIB_HIGH_RST = 10'd900;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST   = 8'd60;

    // Shared divider: dividend is (reading - low) * 255, up to 18 bits
    localparam int DIV_NUM_W = CALIB_W + POS_W;
    localparam int DIV_DEN_W = CALIB_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Input item
    typedef struct packed {
        logic                 cmd;
        logic [TIME_W-1:0]    now_ms;
        logic [CALIB_W-1:0]   wheel_raw;
        logic [BUTTONS-1:0]   pins_raw;
        logic [COUNT_W-1:0]   region_count;
    } t_wbis_in;

    // Result item
    typedef struct packed {
        logic                 sampled;
        logic [POS_W-1:0]     wheel_position;
        logic [BUTTONS-1:0]   buttons_down;
        logic [EVENT_W-1:0]   events;
        logic [POS_W-1:0]     wheel_region;
    } t_wbis_out;

    // Command codes of an input item
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_POLL   = 1'b1;

    // Which division the shared divider is doing
    typedef enum logic [1:0] {
        DIV_SCALE,
        DIV_SIZE,
        DIV_REGION
    } t_wbis_divop;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCALE_GO,
        ST_SCALE_WAIT,
        ST_SIZE_GO,
        ST_SIZE_WAIT,
        ST_REGION_GO,
        ST_REGION_WAIT,
        ST_RESULT
    } t_wbis_state;

    // Controller to datapath
    typedef struct packed {
        logic        load_in;
        logic        eval;
        logic        div_start;
        logic        div_capture;
        t_wbis_divop div_op;
        logic        load_out;
    } t_wbis_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scale;
        logic div_done;
        logic out_free;
    } t_wbis_status;

endpackage

/* rtl/core/wbis_div.sv */
// ----------------------------------------------------------------------------
// wbis_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wbis_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [wbis_pkg::DIV_NUM_W-1:0]   i_dividend,
    input  logic [wbis_pkg::DIV_DEN_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [wbis_pkg::DIV_NUM_W-1:0]   o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [wbis_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [wbis_pkg::DIV_NUM_W-1:0]    r_quo;
    logic [wbis_pkg::DIV_DEN_W-1:0]    r_rem;
    logic [wbis_pkg::DIV_DEN_W-1:0]    r_den;

    logic [wbis_pkg::DIV_DEN_W:0]      rem_sh;
    logic [wbis_pkg::DIV_DEN_W:0]      rem_sub;
    logic                              fits;

    // One trial subtraction per step
    always_comb begin
        rem_sh  = {r_rem, r_quo[wbis_pkg::DIV_NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = (rem_sh >= {1'b0, r_den});
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= wbis_pkg::DIV_CNT_W'(wbis_pkg::DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == wbis_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= rem_sub[wbis_pkg::DIV_DEN_W-1:0];
                r_quo <= {r_quo[wbis_pkg::DIV_NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[wbis_pkg::DIV_DEN_W-1:0];
                r_quo <= {r_quo[wbis_pkg::DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/wbis_datapath.sv */
// ----------------------------------------------------------------------------
// wbis_datapath
// Config registers, sampler state, input latch, shared divider and result
// register.
// ----------------------------------------------------------------------------
module wbis_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wbis_pkg::t_wbis_in                 i_in_data,
    input  logic                               i_cfg_valid,
    input  logic [wbis_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wbis_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_out_ready,
    input  wbis_pkg::t_wbis_cmd                i_cmd,
    output wbis_pkg::t_wbis_status             o_status,
    output logic                               o_out_valid,
    output wbis_pkg::t_wbis_out                o_out_data
);

    // Config registers
    logic [wbis_pkg::CALIB_W-1:0]    r_calib_low;
    logic [wbis_pkg::CALIB_W-1:0]    r_calib_high;
    logic [wbis_pkg::INTERVAL_W-1:0] r_interval;

    // Sampler state
    logic [wbis_pkg::TIME_W-1:0]     r_next_time;
    logic [wbis_pkg::POS_W-1:0]      r_pos;
    logic [wbis_pkg::BUTTONS-1:0]    r_buttons;
    logic [wbis_pkg::BUTTONS-1:0]    r_last_polled;

    // Per-item working registers
    wbis_pkg::t_wbis_in              r_in;
    logic                            r_sampled;
    logic [wbis_pkg::EVENT_W-1:0]    r_events;
    logic [wbis_pkg::POS_W-1:0]      r_size;
    logic [wbis_pkg::POS_W-1:0]      r_region;

    // Result register
    logic                            r_out_valid;
    wbis_pkg::t_wbis_out             r_out;

    logic                            sample_ok;
    logic                            calib_ok;
    logic [wbis_pkg::CALIB_W-1:0]    clamped;
    logic [wbis_pkg::CALIB_W-1:0]    span;
    logic [wbis_pkg::CALIB_W-1:0]    offset;
    logic [wbis_pkg::DIV_NUM_W-1:0]  scale_num;
    logic [wbis_pkg::COUNT_W-1:0]    regions;
    logic [wbis_pkg::COUNT_W-1:0]    last_region;
    logic [wbis_pkg::EVENT_W-1:0]    events_nx;
    logic [wbis_pkg::DIV_NUM_W-1:0]  div_num;
    logic [wbis_pkg::DIV_DEN_W-1:0]  div_den;
    logic                            div_done;
    logic [wbis_pkg::DIV_NUM_W-1:0]  div_quo;
    logic [wbis_pkg::POS_W-1:0]      region_nx;

    // Sample gate, clamp and scale numerator: (t - low) * 255 = (x << 8) - x
    always_comb begin
        sample_ok = (r_in.cmd == wbis_pkg::CMD_SAMPLE) && (r_in.now_ms >= r_next_time);
        calib_ok  = (r_calib_high > r_calib_low);
        if (r_in.wheel_raw > r_calib_high) begin
            clamped = r_calib_high;
        end else if (r_in.wheel_raw < r_calib_low) begin
            clamped = r_calib_low;
        end else begin
            clamped = r_in.wheel_raw;
        end
        span      = r_calib_high - r_calib_low;
        offset    = clamped - r_calib_low;
        scale_num = {offset, {wbis_pkg::POS_W{1'b0}}}
                  - {{wbis_pkg::POS_W{1'b0}}, offset};
    end

    // Region count of zero counts as one region
    always_comb begin
        regions     = (r_in.region_count == '0) ? wbis_pkg::COUNT_W'(1) : r_in.region_count;
        last_region = regions - 1'b1;
    end

    // Press and release edges against the last polled state
    always_comb begin
        for (int k = 0; k < wbis_pkg::BUTTONS; k++) begin
            events_nx[2*k]   = r_buttons[k] & ~r_last_polled[k];
            events_nx[2*k+1] = ~r_buttons[k] & r_last_polled[k];
        end
    end

    // Divider operand select
    always_comb begin
        unique case (i_cmd.div_op)
            wbis_pkg::DIV_SCALE: begin
                div_num = scale_num;
                div_den = span;
            end
            wbis_pkg::DIV_SIZE: begin
                div_num = wbis_pkg::DIV_NUM_W'(wbis_pkg::WHEEL_RANGE);
                div_den = wbis_pkg::DIV_DEN_W'(regions);
            end
            wbis_pkg::DIV_REGION: begin
                div_num = wbis_pkg::DIV_NUM_W'(r_pos);
                div_den = wbis_pkg::DIV_DEN_W'(r_size);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    wbis_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Region from quotient, clamped to the last region; top of travel goes to the last region
    always_comb begin
        if (r_pos >= wbis_pkg::POS_W'(wbis_pkg::WHEEL_RANGE)) begin
            region_nx = last_region;
        end else if (div_quo > wbis_pkg::DIV_NUM_W'(last_region)) begin
            region_nx = last_region;
        end else begin
            region_nx = div_quo[wbis_pkg::POS_W-1:0];
        end
    end

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_low  <= wbis_pkg::CALIB_LOW_RST;
            r_calib_high <= wbis_pkg::CALIB_HIGH_RST;
            r_interval   <= wbis_pkg::INTERVAL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wbis_pkg::CFG_CALIB_LOW:  r_calib_low  <= i_cfg_data;
                wbis_pkg::CFG_CALIB_HIGH: r_calib_high <= i_cfg_data;
                wbis_pkg::CFG_INTERVAL:   r_interval   <= i_cfg_data[wbis_pkg::INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Sampler state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_time   <= '0;
            r_pos         <= '0;
            r_buttons     <= '0;
            r_last_polled <= '0;
        end else begin
            if (i_cmd.eval) begin
                if (sample_ok) begin
                    r_next_time <= r_in.now_ms + wbis_pkg::TIME_W'(r_interval);
                    r_buttons   <= ~r_in.pins_raw;
                    if (!calib_ok) begin
                        r_pos <= '0;
                    end
                end
                if (r_in.cmd == wbis_pkg::CMD_POLL) begin
                    r_last_polled <= r_buttons;
                end
            end
            if (i_cmd.div_capture && div_done && i_cmd.div_op == wbis_pkg::DIV_SCALE) begin
                r_pos <= div_quo[wbis_pkg::POS_W-1:0];
            end
        end
    end

    // Item latch and per-item results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.eval) begin
            r_sampled <= sample_ok;
            r_events  <= (r_in.cmd == wbis_pkg::CMD_POLL) ? events_nx : '0;
        end
        if (i_cmd.div_capture && div_done) begin
            if (i_cmd.div_op == wbis_pkg::DIV_SIZE) begin
                r_size <= div_quo[wbis_pkg::POS_W-1:0];
            end
            if (i_cmd.div_op == wbis_pkg::DIV_REGION) begin
                r_region <= region_nx;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.sampled        <= r_sampled;
            r_out.wheel_position <= r_pos;
            r_out.buttons_down   <= r_buttons;
            r_out.events         <= r_events;
            r_out.wheel_region   <= r_region;
        end
    end

    always_comb begin
        o_status.need_scale = sample_ok && calib_ok;
        o_status.div_done   = div_done;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/core/wbis_ctrl.sv */
// ----------------------------------------------------------------------------
// wbis_ctrl
// Sequencer: takes an item, evaluates it, runs the divisions in turn and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module wbis_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  wbis_pkg::t_wbis_status   i_status,
    output logic                     o_in_ready,
    output wbis_pkg::t_wbis_cmd      o_cmd
);

    wbis_pkg::t_wbis_state r_state;
    wbis_pkg::t_wbis_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wbis_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wbis_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = wbis_pkg::ST_EVAL;
            end
            wbis_pkg::ST_EVAL: begin
                n_state = i_status.need_scale ? wbis_pkg::ST_SCALE_GO : wbis_pkg::ST_SIZE_GO;
            end
            wbis_pkg::ST_SCALE_GO:   n_state = wbis_pkg::ST_SCALE_WAIT;
            wbis_pkg::ST_SCALE_WAIT: begin
                if (i_status.div_done) n_state = wbis_pkg::ST_SIZE_GO;
            end
            wbis_pkg::ST_SIZE_GO:    n_state = wbis_pkg::ST_SIZE_WAIT;
            wbis_pkg::ST_SIZE_WAIT: begin
                if (i_status.div_done) n_state = wbis_pkg::ST_REGION_GO;
            end
            wbis_pkg::ST_REGION_GO:  n_state = wbis_pkg::ST_REGION_WAIT;
            wbis_pkg::ST_REGION_WAIT: begin
                if (i_status.div_done) n_state = wbis_pkg::ST_RESULT;
            end
            wbis_pkg::ST_RESULT: begin
                if (i_status.out_free) n_state = wbis_pkg::ST_IDLE;
            end
            default: n_state = wbis_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.load_in     = 1'b0;
        o_cmd.eval        = 1'b0;
        o_cmd.div_start   = 1'b0;
        o_cmd.div_capture = 1'b0;
        o_cmd.div_op      = wbis_pkg::DIV_SCALE;
        o_cmd.load_out    = 1'b0;
        unique case (r_state)
            wbis_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            wbis_pkg::ST_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            wbis_pkg::ST_SCALE_GO: begin
                o_cmd.div_start = 1'b1;
            end
            wbis_pkg::ST_SCALE_WAIT: begin
                o_cmd.div_capture = 1'b1;
            end
            wbis_pkg::ST_SIZE_GO: begin
                o_cmd.div_op    = wbis_pkg::DIV_SIZE;
                o_cmd.div_start = 1'b1;
            end
            wbis_pkg::ST_SIZE_WAIT: begin
                o_cmd.div_op      = wbis_pkg::DIV_SIZE;
                o_cmd.div_capture = 1'b1;
            end
            wbis_pkg::ST_REGION_GO: begin
                o_cmd.div_op    = wbis_pkg::DIV_REGION;
                o_cmd.div_start = 1'b1;
            end
            wbis_pkg::ST_REGION_WAIT: begin
                o_cmd.div_op      = wbis_pkg::DIV_REGION;
                o_cmd.div_capture = 1'b1;
            end
            wbis_pkg::ST_RESULT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/wheel_and_button_input_sampler_unit.sv */
// ----------------------------------------------------------------------------
// wheel_and_button_input_sampler_unit
// Paced wheel and button sampler with press/release event reporting.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A sample that passes its time gate with
// a valid calibration runs the scaling, the region size and the region
// index divisions before its result loads into the result register; any
// other item skips the scaling division. The divisions run one after
// another on a single shared 18-step restoring divider; each division has
// a start state and then a wait state that ends on the done pulse. A
// finished result sits in an output register, so the next item is taken
// while it waits; a result still stalled there when the next one is ready
// holds the block.
// The configuration port is always ready; write it only while the block
// is idle.
module wheel_and_button_input_sampler_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  wbis_pkg::t_wbis_in                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output wbis_pkg::t_wbis_out               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wbis_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wbis_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    wbis_pkg::t_wbis_cmd    cmd;
    wbis_pkg::t_wbis_status status;

    assign o_cfg_ready = 1'b1;

    wbis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    wbis_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/core/wbis_checker.sv */
// ----------------------------------------------------------------------------
// wbis_checker
// Port-level checks for the wheel and button sampler, bound to the top level.
// ----------------------------------------------------------------------------
module wbis_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  wbis_pkg::t_wbis_out   o_out_data
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // One item at a time: not ready in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

    // A sample result never carries button events
    a_sample_no_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.sampled) |-> (o_out_data.events == '0))
        else $error("sample result with events");

    // Stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind wheel_and_button_input_sampler_unit wbis_checker u_wbis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
